/* rtl/ngfqc_pkg.sv */
package ngfqc_pkg;

   localparam int MAX_LINE_LENGTH = 128;
   localparam int COL_W           = $clog2(MAX_LINE_LENGTH + 1);

   localparam logic [6:0]  SNR_THR_RST  = 7'd30;
   localparam logic [3:0]  GOOD_NEED_RST = 4'd3;
   localparam logic [6:0]  SNR_CAP      = 7'd127;

   localparam logic [23:0] TYPE_GSV = 24'h475356;
   localparam logic [23:0] TYPE_RMC = 24'h524D43;

   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_STAR  = 8'h2A;
   localparam logic [7:0]  CHAR_COMMA = 8'h2C;
   localparam logic [7:0]  CHAR_ZERO  = 8'h30;
   localparam logic [7:0]  CHAR_NINE  = 8'h39;

   // register index = paddr[2]
   localparam logic REG_SNR_THR   = 1'b0;
   localparam logic REG_GOOD_NEED = 1'b1;

   typedef enum logic [1:0] {
      KIND_SKIP  = 2'd0,
      KIND_RMC   = 2'd1,
      KIND_GROUP = 2'd2,
      KIND_END   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      kind_type line_kind;
      logic     fix_good;
   } rsp_type;

endpackage

/* rtl/nmea_gsv_fix_quality_check_top.sv */
// A line end or end mark is judged when it is accepted, and its result is registered.
// Throughput: one request per cycle while req_stall is low; all per-byte work is one
//   compare and a small decimal accumulate between the line state and result registers.
// A result stage plus one skid entry let requests flow while rsp_stall is held,
//   until a second result is waiting; req_stall is high only while the skid entry is full.
// Reset (synchronous, active high) clears line/group state and the fix, empties the
//   result stages and loads snr_threshold = 30, good_needed = 3.
module nmea_gsv_fix_quality_check_top
   import ngfqc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   logic [6:0] snr_thr_ff;
   logic [3:0] good_need_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         snr_thr_ff   <= SNR_THR_RST;
         good_need_ff <= GOOD_NEED_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            REG_SNR_THR:   snr_thr_ff   <= csr_pwdata[6:0];
            REG_GOOD_NEED: good_need_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_SNR_THR:   csr_prdata = {25'd0, snr_thr_ff};
         REG_GOOD_NEED: csr_prdata = {28'd0, good_need_ff};
         default:       csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------
   // Line state (per line) and group state (across lines)
   // ---------------------------------------------------------------
   logic [COL_W-1:0] column_ff,     column_in;
   logic [23:0]      type_ff,       type_in;      // columns 3..5
   logic [6:0]       token_num_ff,  token_num_in; // comma token index, saturates
   logic             nonempty_ff,   nonempty_in;
   logic             past_star_ff,  past_star_in;
   logic             stopped_ff,    stopped_in;   // SNR reading off for this line
   logic [6:0]       snr_ff,        snr_in;       // SNR accumulator
   logic             snr_open_ff,   snr_open_in;  // still in leading digits
   logic             sats_ok_ff,    sats_ok_in;   // column 11 held a digit
   logic [3:0]       grp_size_ff,   grp_size_in;  // pending group size, 1..9
   logic [3:0]       lines_left_ff, lines_left_in;
   logic [6:0]       sats_left_ff,  sats_left_in;
   logic [3:0]       good_cnt_ff,   good_cnt_in;
   logic             decided_ff,    decided_in;
   logic             fix_ff,        fix_in;

   logic             req_fire;
   logic             res_valid;
   kind_type         res_kind;

   assign req_fire = req_valid && !req_stall;

   always_comb begin
      logic [7:0]       c;
      logic             is_dig;
      logic [3:0]       dval;
      logic             take;
      logic [23:0]      type_mid;
      logic [3:0]       gc_mid;
      logic             dec_mid;
      logic [6:0]       sats_mid;
      logic             gsv_start;
      logic             snr_tok;
      logic             ct_stop;
      logic [3:0]       ct_gc;
      logic             ct_dec;
      logic             ct_fix;
      logic [6:0]       ct_sats;
      logic [3:0]       gc_inc;
      logic [10:0]      snr_acc;
      logic [6:0]       sats_acc;
      logic [3:0]       lines_nxt;
      logic             fix_v;
      logic             dec_v;

      c      = req_data.text_byte;
      is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
      dval   = c[3:0];
      take   = req_fire && !req_data.end_of_input && (c != CHAR_LF)
               && (column_ff < COL_W'(MAX_LINE_LENGTH));

      column_in     = column_ff;
      type_in       = type_ff;
      token_num_in  = token_num_ff;
      nonempty_in   = nonempty_ff;
      past_star_in  = past_star_ff;
      stopped_in    = stopped_ff;
      snr_in        = snr_ff;
      snr_open_in   = snr_open_ff;
      sats_ok_in    = sats_ok_ff;
      grp_size_in   = grp_size_ff;
      lines_left_in = lines_left_ff;
      sats_left_in  = sats_left_ff;
      good_cnt_in   = good_cnt_ff;
      decided_in    = decided_ff;
      fix_in        = fix_ff;
      res_valid     = 1'b0;
      res_kind      = KIND_SKIP;
      lines_nxt     = lines_left_ff;
      fix_v         = fix_ff;
      dec_v         = decided_ff;

      // type letters shift in first; a GSV start restarts the group counters
      type_mid = type_ff;
      gc_mid   = good_cnt_ff;
      dec_mid  = decided_ff;
      sats_mid = sats_left_ff;
      if (take && column_ff >= COL_W'(3) && column_ff <= COL_W'(5)) begin
         type_mid = {type_ff[15:0], c};
         if (column_ff == COL_W'(5) && lines_left_ff == 4'd0 && type_mid == TYPE_GSV) begin
            gc_mid   = 4'd0;
            dec_mid  = 1'b0;
            sats_mid = 7'd0;
         end
      end

      gsv_start = (lines_left_ff == 4'd0) && (column_ff >= COL_W'(6))
                  && (type_mid == TYPE_GSV);

      // satellites in view, columns 11 and 12
      sats_acc = 7'((sats_mid * 7'd10) + {3'd0, dval});
      if (take && gsv_start && column_ff == COL_W'(11)) begin
         sats_mid = is_dig ? {3'd0, dval} : 7'd0;
      end else if (take && gsv_start && column_ff == COL_W'(12) && sats_ok_ff && is_dig) begin
         sats_mid = sats_acc;
      end

      // token close: SNR tokens are 7, 11, 15, ...
      snr_tok = (token_num_ff >= 7'd7) && (token_num_ff[1:0] == 2'b11);
      ct_stop = stopped_ff;
      ct_gc   = gc_mid;
      ct_dec  = dec_mid;
      ct_fix  = fix_ff;
      ct_sats = sats_mid;
      gc_inc  = (gc_mid == 4'd15) ? gc_mid : gc_mid + 4'd1;
      if (snr_tok && (lines_left_ff != 4'd0 || gsv_start) && !stopped_ff && !dec_mid) begin
         if (!nonempty_ff || sats_mid == 7'd0) begin
            ct_stop = 1'b1;
         end else begin
            if (snr_ff >= snr_thr_ff) begin
               ct_gc = gc_inc;
               if (gc_inc >= good_need_ff) begin
                  ct_fix = 1'b1;
                  ct_dec = 1'b1;
               end
            end
            ct_sats = sats_mid - 7'd1;
         end
      end

      snr_acc = ({4'd0, snr_ff} * 11'd10) + {7'd0, dval};

      if (take) begin
         type_in      = type_mid;
         good_cnt_in  = gc_mid;
         decided_in   = dec_mid;
         sats_left_in = sats_mid;
         if (gsv_start && column_ff == COL_W'(7)) begin
            grp_size_in = (is_dig && c != CHAR_ZERO) ? dval : 4'd1;
         end
         if (gsv_start && column_ff == COL_W'(11)) begin
            sats_ok_in = is_dig;
         end
         if (!past_star_ff) begin
            if (c == CHAR_STAR || c == CHAR_COMMA) begin
               stopped_in   = ct_stop;
               good_cnt_in  = ct_gc;
               decided_in   = ct_dec;
               fix_in       = ct_fix;
               sats_left_in = ct_sats;
               nonempty_in  = 1'b0;
               snr_in       = 7'd0;
               snr_open_in  = 1'b1;
               if (c == CHAR_STAR) begin
                  past_star_in = 1'b1;
               end else if (token_num_ff != 7'd127) begin
                  token_num_in = token_num_ff + 7'd1;
               end
            end else begin
               nonempty_in = 1'b1;
               if (snr_open_ff && is_dig) begin
                  snr_in = (snr_acc > 11'(SNR_CAP)) ? SNR_CAP : snr_acc[6:0];
               end else begin
                  snr_open_in = 1'b0;
               end
            end
         end
         column_in = column_ff + COL_W'(1);
      end else if (req_fire && req_data.end_of_input) begin
         // open group ends without a group result
         if (lines_left_ff != 4'd0) begin
            if (!decided_ff) fix_in = 1'b0;
            lines_left_in = 4'd0;
         end
         res_valid = 1'b1;
         res_kind  = KIND_END;
      end else if (req_fire && c == CHAR_LF) begin
         if (!past_star_ff) begin
            stopped_in   = ct_stop;
            good_cnt_in  = ct_gc;
            dec_v        = ct_dec;
            fix_v        = ct_fix;
            sats_left_in = ct_sats;
         end
         decided_in = dec_v;
         fix_in     = fix_v;
         res_valid  = 1'b1;
         priority if (lines_left_ff != 4'd0) begin
            lines_nxt     = lines_left_ff - 4'd1;
            lines_left_in = lines_nxt;
            if (lines_nxt == 4'd0) begin
               if (!dec_v) fix_in = 1'b0;
               res_kind = KIND_GROUP;
            end else begin
               res_valid = 1'b0;
            end
         end else if (column_ff >= COL_W'(6) && type_ff == TYPE_RMC) begin
            res_kind = KIND_RMC;
         end else if (gsv_start && column_ff >= COL_W'(13)) begin
            lines_nxt     = grp_size_ff - 4'd1;
            lines_left_in = lines_nxt;
            if (lines_nxt == 4'd0) begin
               if (!dec_v) fix_in = 1'b0;
               res_kind = KIND_GROUP;
            end else begin
               res_valid = 1'b0;
            end
         end else begin
            res_kind = KIND_SKIP;
         end
      end

      // line end and end mark both start a fresh line
      if (req_fire && (req_data.end_of_input || c == CHAR_LF)) begin
         column_in    = '0;
         type_in      = 24'd0;
         token_num_in = 7'd0;
         nonempty_in  = 1'b0;
         past_star_in = 1'b0;
         stopped_in   = 1'b0;
         snr_in       = 7'd0;
         snr_open_in  = 1'b1;
         sats_ok_in   = 1'b0;
         grp_size_in  = 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff     <= '0;
         type_ff       <= 24'd0;
         token_num_ff  <= 7'd0;
         nonempty_ff   <= 1'b0;
         past_star_ff  <= 1'b0;
         stopped_ff    <= 1'b0;
         snr_ff        <= 7'd0;
         snr_open_ff   <= 1'b1;
         sats_ok_ff    <= 1'b0;
         grp_size_ff   <= 4'd1;
         lines_left_ff <= 4'd0;
         sats_left_ff  <= 7'd0;
         good_cnt_ff   <= 4'd0;
         decided_ff    <= 1'b0;
         fix_ff        <= 1'b0;
      end else begin
         column_ff     <= column_in;
         type_ff       <= type_in;
         token_num_ff  <= token_num_in;
         nonempty_ff   <= nonempty_in;
         past_star_ff  <= past_star_in;
         stopped_ff    <= stopped_in;
         snr_ff        <= snr_in;
         snr_open_ff   <= snr_open_in;
         sats_ok_ff    <= sats_ok_in;
         grp_size_ff   <= grp_size_in;
         lines_left_ff <= lines_left_in;
         sats_left_ff  <= sats_left_in;
         good_cnt_ff   <= good_cnt_in;
         decided_ff    <= decided_in;
         fix_ff        <= fix_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register plus one skid entry. The request side stalls only
   // while the skid entry is occupied.
   // ---------------------------------------------------------------
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff,  rsp_data_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type skid_data_ff,  skid_data_in;
   rsp_type res_data;
   logic    rsp_take;

   assign res_data.line_kind = res_kind;
   assign res_data.fix_good  = fix_in;
   assign rsp_take           = rsp_valid_ff && !rsp_stall;
   assign req_stall          = skid_valid_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_data           = rsp_data_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      priority if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (res_valid) begin
         if (!rsp_valid_ff || rsp_take) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = res_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   // skid entry is only used behind a held result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry valid with empty result register");

   // a decided group always carries a good fix
   a_decided_fix: assert property (@(posedge clock) disable iff (reset)
      decided_ff |-> fix_ff)
      else $error("group decided but fix not set");

   // remaining group lines come from one digit minus one
   a_lines_range: assert property (@(posedge clock) disable iff (reset)
      lines_left_ff <= 4'd8)
      else $error("group line count out of range");

   // satellites in view come from two digits
   a_sats_range: assert property (@(posedge clock) disable iff (reset)
      sats_left_ff <= 7'd99)
      else $error("satellite count out of range");

endmodule

/* dv/nmea_gsv_fix_quality_check_top_test.sv */
`timescale 1ns / 100ps

module nmea_gsv_fix_quality_check_top_test;
   import ngfqc_pkg::*;

   // register map: one 32-bit word per register
   localparam bit [2:0] SNR_THR_ADDR   = {REG_SNR_THR, 2'b00};
   localparam bit [2:0] GOOD_NEED_ADDR = {REG_GOOD_NEED, 2'b00};

   localparam int RANDOM_ITEMS = 720;    // bytes in the random part
   localparam int SEG_ITEMS    = 120;    // bytes per random segment (one setting each)
   localparam int HOLD_CYCLES  = 300;    // long result back-pressure stretch
   localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake before giving up

   // Follows every request, predicts the line kind and fix verdict of each result and holds the
   // verdicts still due on the result channel.
   class fix_scoreboard;
      bit [6:0]  snr_thr;
      bit [3:0]  good_need;
      // line state
      bit [7:0]  col;
      bit [23:0] type_chars;
      bit [6:0]  field_no;
      bit        field_used;
      bit        past_star;
      bit        line_stopped;
      bit [6:0]  snr_acc;
      bit        snr_open;
      bit        sats_ok;
      bit [3:0]  pend_size;
      // group state
      bit [3:0]  lines_left;
      bit [6:0]  sats_left;
      bit [3:0]  good_cnt;
      bit        decided;
      bit        fix;

      rsp_type     due_results[$];
      int unsigned fail_count;

      function new();
         snr_thr    = SNR_THR_RST;
         good_need  = GOOD_NEED_RST;
         lines_left = 0;
         sats_left  = 0;
         good_cnt   = 0;
         decided    = 0;
         fix        = 0;
         fail_count = 0;
         clear_line();
      endfunction

      function void clear_line();
         col          = 0;
         type_chars   = 0;
         field_no     = 0;
         field_used   = 0;
         past_star    = 0;
         line_stopped = 0;
         snr_acc      = 0;
         snr_open     = 1;
         sats_ok      = 0;
         pend_size    = 1;
      endfunction

      function bit is_digit(bit [7:0] ch);
         return ch >= CHAR_ZERO && ch <= CHAR_NINE;
      endfunction

      // first line of a group, header already past the type letters
      function bit gsv_opening();
         return lines_left == 0 && col >= 6 && type_chars == TYPE_GSV;
      endfunction

      // comma token closes; SNR fields are tokens 7, 11, 15, ...
      function void close_field();
         if ((lines_left != 0 || gsv_opening()) && !line_stopped && !decided &&
             field_no >= 7 && field_no[1:0] == 2'd3) begin
            if (!field_used || sats_left == 0) begin
               line_stopped = 1;
            end else begin
               if (snr_acc >= snr_thr) begin
                  if (good_cnt != 4'd15) good_cnt++;
                  if (good_cnt >= good_need) begin
                     fix     = 1;
                     decided = 1;
                  end
               end
               sats_left--;
            end
         end
         field_used = 0;
         snr_acc    = 0;
         snr_open   = 1;
      endfunction

      function void end_group();
         if (!decided) fix = 0;
         lines_left = 0;
      endfunction

      // appends one verdict at the tail of the due list
      function void queue_result(rsp_type verdict);
         due_results = {due_results, verdict};
      endfunction

      function void write_register(bit [2:0] addr, bit [31:0] value);
         if (addr[2] == REG_GOOD_NEED) good_need = value[3:0];
         else snr_thr = value[6:0];
      endfunction

      function void take_request(req_type item);
         bit [7:0] ch;
         bit       has_result;
         rsp_type  verdict;
         int       acc;
         ch = item.text_byte;
         has_result = 1;
         verdict.line_kind = KIND_SKIP;
         verdict.fix_good  = 1'b0;
         if (item.end_of_input) begin
            // open group dies here without a group result
            if (lines_left != 0) end_group();
            clear_line();
            verdict.line_kind = KIND_END;
         end else if (ch != CHAR_LF) begin
            has_result = 0;
            if (col < MAX_LINE_LENGTH) begin
               if (col >= 3 && col <= 5) begin
                  type_chars = {type_chars[15:0], ch};
                  if (col == 5 && lines_left == 0 && type_chars == TYPE_GSV) begin
                     good_cnt  = 0;
                     decided   = 0;
                     sats_left = 0;
                  end
               end
               if (gsv_opening()) begin
                  if (col == 7)
                     pend_size = (is_digit(ch) && ch != CHAR_ZERO) ? ch[3:0] : 4'd1;
                  if (col == 11) begin
                     sats_ok   = is_digit(ch);
                     sats_left = sats_ok ? 7'(ch[3:0]) : 7'd0;
                  end
                  if (col == 12 && sats_ok && is_digit(ch))
                     sats_left = sats_left * 7'd10 + 7'(ch[3:0]);
               end
               if (!past_star) begin
                  if (ch == CHAR_STAR) begin
                     close_field();
                     past_star = 1;
                  end else if (ch == CHAR_COMMA) begin
                     close_field();
                     if (field_no != 7'd127) field_no++;
                  end else begin
                     field_used = 1;
                     if (snr_open && is_digit(ch)) begin
                        acc = snr_acc * 10 + ch[3:0];
                        snr_acc = (acc > SNR_CAP) ? SNR_CAP : 7'(acc);
                     end else begin
                        snr_open = 0;
                     end
                  end
               end
               col++;
            end
         end else begin
            if (!past_star) close_field();
            if (lines_left != 0) begin
               lines_left--;
               if (lines_left == 0) begin
                  end_group();
                  verdict.line_kind = KIND_GROUP;
               end else begin
                  has_result = 0;
               end
            end else if (col >= 6 && type_chars == TYPE_RMC) begin
               verdict.line_kind = KIND_RMC;
            end else if (gsv_opening() && col >= 13) begin
               lines_left = pend_size - 4'd1;
               if (lines_left == 0) begin
                  end_group();
                  verdict.line_kind = KIND_GROUP;
               end else begin
                  has_result = 0;
               end
            end
            clear_line();
         end
         if (has_result) begin
            verdict.fix_good = fix;
            queue_result(verdict);
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (due_results.size() == 0) begin
            $error("result with nothing due: line_kind %0d fix_good %0b",
                   got.line_kind, got.fix_good);
            fail_count++;
            return;
         end
         want = due_results.pop_front();
         if (got.line_kind !== want.line_kind) begin
            $error("line_kind: expected %0d, actual %0d", want.line_kind, got.line_kind);
            fail_count++;
         end
         if (got.fix_good !== want.fix_good) begin
            $error("fix_good: expected %0b, actual %0b", want.fix_good, got.fix_good);
            fail_count++;
         end
      endfunction
   endclass

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   fix_scoreboard sb;

   int          tx_idle_pct = 0;   // sender gap odds, percent per cycle
   int          rx_idle_pct = 0;   // receiver stall odds, percent per cycle
   int unsigned hold_asked  = 0;   // bumped by the main flow to ask for a long hold
   int unsigned hold_seen   = 0;
   int unsigned hold_left   = 0;
   int unsigned sent_count  = 0;

   nmea_gsv_fix_quality_check_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #10 clock = ~clock;

   // Result side: random stalls, or a long hold counted here once asked for.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   // Results are sampled at the edge that accepts them.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
   end

   // Watchdog: too long without any handshake means the block hung.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("Verification failed");
      $finish;
   end

   // One request; random gaps ahead of it, then held until accepted.
   task automatic send_request(req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.take_request(item);
      sent_count++;
   endtask

   task automatic send_byte(bit [7:0] ch);
      req_type item;
      item.text_byte    = ch;
      item.end_of_input = 1'b0;
      send_request(item);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // end-of-stream mark; the byte rides along with random content
   task automatic send_end();
      req_type item;
      item.text_byte    = 8'($urandom_range(255));
      item.end_of_input = 1'b1;
      send_request(item);
   endtask

   // Sender stops until every due result is in, plus margin for a line
   // end still in flight that gives no result.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup phase, then access until pready, then back to idle.
   task automatic write_csr(bit [2:0] addr, bit [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      sb.write_register(addr, value);
      @(posedge clock);
   endtask

   function automatic bit [7:0] letter();
      return 8'("A" + $urandom_range(25));
   endfunction

   // SNR field text: empty, in range, 100..999, trailing junk, leading junk, zero-padded
   function automatic string snr_text();
      int r;
      r = $urandom_range(99);
      if (r < 15) return "";
      if (r < 65) return $sformatf("%0d", $urandom_range(99));
      if (r < 75) return $sformatf("%0d", $urandom_range(100, 999));
      if (r < 85) return $sformatf("%0d%c", $urandom_range(99), letter());
      if (r < 92) return $sformatf("%c%0d", letter(), $urandom_range(99));
      return $sformatf("%03d", $urandom_range(60));
   endfunction

   function automatic string gsv_text(bit [7:0] size_ch, bit [7:0] msg_ch);
      string s;
      int    r;
      int    blocks;
      s = $sformatf("$G%cGSV,%c,%c,", $urandom_range(1) ? "P" : "L", size_ch, msg_ch);
      // satellites in view at columns 11..12
      r = $urandom_range(99);
      if (r < 80)      s = {s, $sformatf("%02d", $urandom_range(16))};
      else if (r < 88) s = {s, $sformatf("%02d", $urandom_range(17, 99))};
      else if (r < 94) s = {s, $sformatf("%c%0d", letter(), $urandom_range(9))};
      else             s = {s, $sformatf("%0d%c", $urandom_range(9), letter())};
      blocks = ($urandom_range(99) < 90) ? $urandom_range(4) : $urandom_range(5, 11);
      repeat (blocks)
         s = {s, $sformatf(",%02d,%02d,%03d,%s", $urandom_range(99), $urandom_range(90),
                           $urandom_range(359), snr_text())};
      r = $urandom_range(99);
      if (r < 80)      s = {s, $sformatf("*%02X\r\n", $urandom_range(255))};
      else if (r < 90) s = {s, "\r\n"};
      else if (r < 95) s = {s, "\n"};
      else             s = {s, ",\r\n"};
      return s;
   endfunction

   function automatic string rmc_text();
      return $sformatf("$GPRMC,%06d,%c,%04d.%03d,N*%02X\r\n", $urandom_range(235959),
                       $urandom_range(1) ? "A" : "V", $urandom_range(9999),
                       $urandom_range(999), $urandom_range(255));
   endfunction

   // line past the column limit; tail bytes must be ignored
   task automatic send_long_line();
      send_text($urandom_range(1) ? "$GPRMC," : "$GPZDA,");
      repeat ($urandom_range(125, 160)) send_byte(8'($urandom_range(32, 126)));
      send_text("\r\n");
   endtask

   // Well-formed group with random content; now and then cut short by an end mark.
   task automatic send_gsv_group();
      bit [7:0] size_ch;
      int       r;
      int       span;
      r = $urandom_range(99);
      if (r < 70)      size_ch = 8'("1" + $urandom_range(2));
      else if (r < 80) size_ch = 8'("4" + $urandom_range(5));
      else if (r < 90) size_ch = "0";
      else             size_ch = letter();
      span = (size_ch >= "1" && size_ch <= "9") ? size_ch - "0" : 1;
      send_text(gsv_text(size_ch, "1"));
      for (int i = 2; i <= span; i++) begin
         r = $urandom_range(99);
         if (r < 6) begin
            send_end();
            return;
         end
         if (r < 85)      send_text(gsv_text(size_ch, 8'("0" + i)));
         else if (r < 95) send_text(rmc_text());
         else             send_text("\r\n");
      end
   endtask

   task automatic send_random_stanza();
      string s;
      int    r;
      r = $urandom_range(99);
      if (r < 50) begin
         send_gsv_group();
      end else if (r < 60) begin
         send_text(rmc_text());
      end else if (r < 70) begin
         case ($urandom_range(5))
            0:       send_text("\n");
            1:       send_text("\r\n");
            2:       send_text("$GP\r\n");
            3:       send_text("$GPGS\n");
            4:       send_text("$GPGSV,3,1\r\n");
            default: send_text("$GPGSV,2,1,0\r\n");
         endcase
      end else if (r < 80) begin
         // raw noise, any byte value
         repeat ($urandom_range(24)) send_byte(8'($urandom_range(255)));
         send_byte(CHAR_LF);
      end else if (r < 85) begin
         send_end();
      end else if (r < 90) begin
         send_long_line();
      end else if (r < 95) begin
         send_text($sformatf("$GPGGA,%0d,%0d,%0d,%0d,%0d,%0d,%0d,%0d\r\n",
                             $urandom_range(999), $urandom_range(999), $urandom_range(99),
                             $urandom_range(99), $urandom_range(200), $urandom_range(9),
                             $urandom_range(99), $urandom_range(99)));
      end else begin
         // unterminated line dropped by an end mark
         s = gsv_text("1", "1");
         send_text(s.substr(0, $urandom_range(1, s.len() - 3) - 1));
         send_end();
      end
   endtask

   // Settings per random segment, extremes included.
   bit [6:0] thr_set  [6] = '{7'd0, 7'd99, 7'd127, 7'd45, 7'd20, 7'd60};
   bit [3:0] need_set [6] = '{4'd1, 4'd12, 4'd15, 4'd0, 4'd2, 4'd4};

   initial begin
      int          seg;
      int unsigned base_sent;
      int unsigned seg_start;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings (threshold 30, three good needed).
      send_text("\n");                                   // empty line
      send_text("\r\n");                                 // CR LF only
      send_text("$GPRMC,123519,A,4807.038,N*6A\r\n");    // time line
      send_text("$GPGSV,1,1\r\n");                       // GSV too short to open
      send_text("$GPGSV,1,1,03,01,40,083,46,02,17,308,41,12,07,344,39*75\r\n");
      send_text("$GPGSV,0,1,04,01,40,083,,02,17,308,41*75\r\n");   // size 0, empty SNR
      send_text("$GPGSV,2,1,0X,01,40,083,46*70\r\n");    // bad second sats digit
      send_text("$GPGGA,1,2,3,4,5,6,99,8\r\n");          // any text closes the group
      send_text("$GPGSV,1,1,X9,01,40,083,46*70\r\n");    // bad first sats digit
      send_text("$GPGSV,x,1,12,01,40,083,999,02,17,308,128,03,1,1,127x*00\r\n");
      send_text("$GPGSV,3,1,05,01,40,083,10*00\r\n");    // group left open
      send_end();
      send_end();                                        // repeated end mark
      send_text("$GPGSV,1,1,04,01,02,03,50");            // unterminated
      send_end();
      send_long_line();

      // Random segments: new setting and idle pattern each time.
      base_sent = sent_count;
      seg = 0;
      while (sent_count - base_sent < RANDOM_ITEMS) begin
         drain_results();
         write_csr(SNR_THR_ADDR, ($urandom & ~32'h7F) | 32'(thr_set[seg % 6]));
         write_csr(GOOD_NEED_ADDR, ($urandom & ~32'hF) | 32'(need_set[seg % 6]));
         case (seg % 3)
            0: begin
               tx_idle_pct = 9;
               rx_idle_pct <= 64;
            end
            1: begin
               tx_idle_pct = 64;
               rx_idle_pct <= 9;
            end
            default: begin
               // no idling, plus a long result hold so the input backs up
               tx_idle_pct = 0;
               rx_idle_pct <= 0;
               hold_asked  <= hold_asked + 1;
            end
         endcase
         seg_start = sent_count;
         while (sent_count - seg_start < SEG_ITEMS) send_random_stanza();
         seg++;
      end

      drain_results();
      repeat (6) @(posedge clock);
      if (sb.fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ngfqc_pkg.sv
rtl/nmea_gsv_fix_quality_check_top.sv
dv/nmea_gsv_fix_quality_check_top_test.sv
